### hw/rtl/elsh_pkg.sv
package elsh_pkg;

	localparam int DIM_DEF        = 128;
	localparam int NUM_FUNCS_DEF  = 8;
	localparam int NUM_TABLES_DEF = 8;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 64;
	localparam int CFG_W     = 24;
	localparam int WIN_W     = 24;
	localparam int TS_W      = 24;
	localparam int FUNCS_W   = 5;
	localparam int TAB_W     = 4;
	localparam int FN_W      = 4;
	localparam int CI_W      = 10;
	localparam int DATA_W    = 32;
	localparam int ACC_W     = 48;
	localparam int PROJ_W    = 16;
	localparam int COORD_W   = 16;
	localparam int OFF_W     = 24;
	localparam int MULT_W    = 31;
	localparam int HASH_W    = 32;
	localparam int DVD_W     = 49;
	localparam int DVS_W     = 24;

	localparam logic [WIN_W-1:0]   WINDOW_RST = 24'd16384;
	localparam logic [TS_W-1:0]    TS_RST     = 24'd1024;
	localparam logic [FUNCS_W-1:0] FUNCS_RST  = 5'd8;

	typedef enum logic [1:0] {
		REQ_COORD  = 2'd0,
		REQ_PROJ   = 2'd1,
		REQ_OFFSET = 2'd2,
		REQ_MULT   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		CFG_WINDOW     = 2'd0,
		CFG_TABLE_SIZE = 2'd1,
		CFG_MODE       = 2'd2,
		CFG_FUNCS      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quot;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

endpackage

### hw/rtl/elsh_div.sv
module elsh_div (
	input  logic               clk,
	input  logic               arst_n,
	input  elsh_pkg::div_req_t req,
	output elsh_pkg::div_rsp_t rsp
);
	import elsh_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W:0]   rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             ge;

	// one restoring step per cycle, dividend bits enter msb first
	assign trial = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q[DVS_W-1:0];

endmodule

### hw/rtl/euclidean_lsh_bucket_hash.sv
// channel  direction  fields (tdata low bit up / tuser / tlast)
// s_*      in         table_sel, func_sel, coord_index, data_value / req_type / last_coord
// m_*      out        func_index, hash_value, bucket_index / - / last_result
// cfg_*    in         register write: window_width, table_size, bucket_mode, funcs_in_use
//
// load items are taken while idle and leave s_tready high; a coordinate takes one
// projection memory read and one accumulator read-modify-write per function.
// a last coordinate then runs each function in use through the shared 49-step divider,
// then the bucket division, then emits one result per cycle while m_tready is high.
// arst_n clears control state; memories hold garbage until loaded, accumulators
// read as zero through valid bits. a stalled m_tready holds the emit sequence.
module euclidean_lsh_bucket_hash #(
	parameter int DIM        = elsh_pkg::DIM_DEF,
	parameter int NUM_FUNCS  = elsh_pkg::NUM_FUNCS_DEF,
	parameter int NUM_TABLES = elsh_pkg::NUM_TABLES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// table_sel, func_sel, coord_index, data_value
	input  logic [elsh_pkg::S_TDATA_W-1:0] s_tdata,
	// req_type
	input  logic [1:0]                     s_tuser,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// func_index, hash_value, bucket_index
	output logic [elsh_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tlast,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_addr,
	input  logic [elsh_pkg::CFG_W-1:0]     cfg_wdata
);
	import elsh_pkg::*;

	localparam int PROJ_D = NUM_TABLES * NUM_FUNCS * DIM;
	localparam int OFF_D  = NUM_TABLES * NUM_FUNCS;
	localparam int PA_W   = (PROJ_D > 1) ? $clog2(PROJ_D) : 1;
	localparam int OA_W   = (OFF_D > 1) ? $clog2(OFF_D) : 1;
	localparam int FI_W   = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
	localparam int FC_W   = $clog2(NUM_FUNCS + 1);
	localparam int POS_W  = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int N_W    = ACC_W + 2;
	localparam int Q_W    = DVD_W + 2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ACC, ST_DRAIN, ST_FIN_RD, ST_FIN_CALC, ST_FIN_DIV,
		ST_FIN_MUL, ST_FIN_SUM, ST_BKT_ST, ST_BKT_DIV, ST_EMIT
	} state_t;

	// configuration
	logic [WIN_W-1:0]   window_q;
	logic [TS_W-1:0]    tsize_q;
	logic               mode_q;
	logic [FUNCS_W-1:0] funcs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
			tsize_q  <= TS_RST;
			mode_q   <= 1'b0;
			funcs_q  <= FUNCS_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				CFG_WINDOW:     window_q <= cfg_wdata[WIN_W-1:0];
				CFG_TABLE_SIZE: tsize_q  <= cfg_wdata[TS_W-1:0];
				CFG_MODE:       mode_q   <= cfg_wdata[0];
				CFG_FUNCS:      funcs_q  <= cfg_wdata[FUNCS_W-1:0];
				default:        ;
			endcase
		end
	end

	logic [FC_W-1:0]  k_use;
	logic [DVS_W-1:0] win_eff;
	logic [DVS_W-1:0] ts_eff;

	always_comb begin
		if (funcs_q == '0)
			k_use = FC_W'(1);
		else if (32'(funcs_q) > NUM_FUNCS)
			k_use = FC_W'(NUM_FUNCS);
		else
			k_use = FC_W'(funcs_q);
	end
	assign win_eff = (window_q == '0) ? DVS_W'(1) : window_q;
	assign ts_eff  = (tsize_q == '0) ? DVS_W'(1) : tsize_q;

	// input fields
	logic [TAB_W-1:0]  in_tab;
	logic [FN_W-1:0]   in_fn;
	logic [CI_W-1:0]   in_ci;
	logic [DATA_W-1:0] in_data;
	logic              s_xfer;

	assign in_tab  = s_tdata[3:0];
	assign in_fn   = s_tdata[7:4];
	assign in_ci   = s_tdata[17:8];
	assign in_data = s_tdata[49:18];
	assign s_xfer  = s_tvalid && s_tready;

	state_t               state_q;
	logic [FC_W-1:0]      f_q;
	logic [POS_W-1:0]     pos_q;
	logic [POS_W-1:0]     cur_pos_q;
	logic [TAB_W-1:0]     tab_q;
	logic                 last_q;
	logic signed [COORD_W-1:0] x_q;
	logic                 tab_ok;

	assign tab_ok = 32'(tab_q) < NUM_TABLES;

	// memories
	logic [PROJ_W-1:0] proj_mem [PROJ_D];
	logic [OFF_W-1:0]  off_mem  [OFF_D];
	logic [MULT_W-1:0] mult_mem [NUM_FUNCS];
	logic [ACC_W-1:0]  acc_mem  [NUM_FUNCS];
	logic [NUM_FUNCS-1:0] acc_vld_q;

	logic [PROJ_W-1:0] proj_rd_q;
	logic [OFF_W-1:0]  off_rd_q;
	logic [MULT_W-1:0] mult_rd_q;
	logic [ACC_W-1:0]  acc_rd_q;
	logic              accv_rd_q;

	logic [FI_W-1:0] f_idx;
	logic [PA_W-1:0] proj_rd_addr;
	logic [OA_W-1:0] off_rd_addr;
	logic [PA_W-1:0] proj_wr_addr;
	logic [OA_W-1:0] off_wr_addr;
	logic            load_proj;
	logic            load_off;
	logic            load_mult;

	assign f_idx        = f_q[FI_W-1:0];
	assign proj_rd_addr = PA_W'((32'(tab_q) * NUM_FUNCS + 32'(f_idx)) * DIM + 32'(cur_pos_q));
	assign off_rd_addr  = OA_W'(32'(tab_q) * NUM_FUNCS + 32'(f_idx));
	assign proj_wr_addr = PA_W'((32'(in_tab) * NUM_FUNCS + 32'(in_fn)) * DIM + 32'(in_ci));
	assign off_wr_addr  = OA_W'(32'(in_tab) * NUM_FUNCS + 32'(in_fn));

	assign load_proj = s_xfer && (req_kind_t'(s_tuser) == REQ_PROJ)
		&& (32'(in_tab) < NUM_TABLES) && (32'(in_fn) < NUM_FUNCS) && (32'(in_ci) < DIM);
	assign load_off  = s_xfer && (req_kind_t'(s_tuser) == REQ_OFFSET)
		&& (32'(in_tab) < NUM_TABLES) && (32'(in_fn) < NUM_FUNCS);
	assign load_mult = s_xfer && (req_kind_t'(s_tuser) == REQ_MULT)
		&& (32'(in_fn) < NUM_FUNCS);

	always_ff @(posedge clk) begin
		if (load_proj)
			proj_mem[proj_wr_addr] <= in_data[PROJ_W-1:0];
		proj_rd_q <= proj_mem[proj_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (load_off)
			off_mem[off_wr_addr] <= in_data[OFF_W-1:0];
		off_rd_q <= off_mem[off_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (load_mult)
			mult_mem[in_fn[FI_W-1:0]] <= in_data[MULT_W-1:0];
		mult_rd_q <= mult_mem[f_idx];
	end

	// multiply-accumulate pipeline: read, multiply, write back
	logic                       vld_s1, vld_s2;
	logic [FI_W-1:0]            f_s1, f_s2;
	logic signed [2*PROJ_W-1:0] prod_s2;
	logic [ACC_W-1:0]           acc_s2;
	logic                       acc_we;

	assign acc_we = vld_s2 && tab_ok;

	always_ff @(posedge clk) begin
		if (acc_we)
			acc_mem[f_s2] <= acc_s2 + ACC_W'(prod_s2);
		acc_rd_q <= acc_mem[f_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			accv_rd_q <= 1'b0;
		end else begin
			vld_s1    <= (state_q == ST_ACC);
			vld_s2    <= vld_s1;
			accv_rd_q <= acc_vld_q[f_idx];
		end
	end

	always_ff @(posedge clk) begin
		f_s1    <= f_idx;
		f_s2    <= f_s1;
		prod_s2 <= x_q * $signed(proj_rd_q);
		acc_s2  <= accv_rd_q ? acc_rd_q : '0;
	end

	// hash and bucket
	div_req_t div_req;
	div_rsp_t div_rsp;

	elsh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	logic signed [N_W-1:0]    n_val;
	logic [DVD_W-1:0]         n_abs;
	logic                     neg_q;
	logic signed [Q_W-1:0]    q_floor;
	logic signed [HASH_W-1:0] hv;
	logic signed [HASH_W-1:0] hv_q;
	logic [HASH_W-1:0]        hash_q [NUM_FUNCS];
	logic [HASH_W-1:0]        mprod_q;
	logic [HASH_W-1:0]        sum_q;
	logic [NUM_FUNCS-1:0]     bits_q;
	logic [HASH_W-1:0]        sum_abs;
	logic [TS_W-1:0]          bucket_q;
	logic [ACC_W-1:0]         dot;

	assign dot   = accv_rd_q ? acc_rd_q : '0;
	assign n_val = N_W'($signed(dot)) + $signed({2'b00, (tab_ok ? off_rd_q : OFF_W'(0))});
	assign n_abs = n_val[N_W-1] ? DVD_W'(-n_val) : DVD_W'(n_val);

	always_comb begin
		if (neg_q)
			q_floor = -$signed({2'b00, div_rsp.quot}) - Q_W'(div_rsp.rem != '0);
		else
			q_floor = $signed({2'b00, div_rsp.quot});
		if (q_floor > Q_W'(32'sh7fff_ffff))
			hv = 32'sh7fff_ffff;
		else if (q_floor < -Q_W'(33'sh0_8000_0000))
			hv = 32'sh8000_0000;
		else
			hv = q_floor[HASH_W-1:0];
	end

	assign sum_abs = sum_q[HASH_W-1] ? (~sum_q + 1'b1) : sum_q;

	always_comb begin
		div_req.start    = (state_q == ST_FIN_CALC) || (state_q == ST_BKT_ST);
		div_req.divisor  = (state_q == ST_BKT_ST) ? ts_eff : win_eff;
		if (state_q == ST_BKT_ST)
			div_req.dividend = mode_q ? DVD_W'(bits_q) : DVD_W'(sum_abs);
		else
			div_req.dividend = n_abs;
	end

	// output register
	logic                 m_vld_q;
	logic [M_TDATA_W-1:0] m_data_q;
	logic                 m_last_q;
	logic                 m_load;

	assign m_load = (state_q == ST_EMIT) && (!m_vld_q || m_tready);

	always_ff @(posedge clk) begin
		if (m_load) begin
			m_data_q <= {4'b0000, bucket_q, hash_q[f_idx], FN_W'(f_q)};
			m_last_q <= (f_q == k_use - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN_DIV && div_rsp.done)
			hash_q[f_idx] <= hv;
		if (state_q == ST_FIN_DIV && div_rsp.done)
			hv_q <= hv;
		if (state_q == ST_FIN_MUL)
			mprod_q <= HASH_W'(HASH_W'(mult_rd_q) * hv_q);
		if (state_q == ST_DRAIN) begin
			sum_q  <= '0;
			bits_q <= '0;
		end else if (state_q == ST_FIN_SUM) begin
			sum_q  <= sum_q + mprod_q;
			bits_q <= (bits_q << 1) | NUM_FUNCS'(hv_q[0]);
		end
		if (state_q == ST_FIN_CALC)
			neg_q <= n_val[N_W-1];
		if (state_q == ST_BKT_DIV && div_rsp.done)
			bucket_q <= div_rsp.rem;
		if (s_xfer && req_kind_t'(s_tuser) == REQ_COORD) begin
			x_q       <= $signed(in_data[COORD_W-1:0]);
			tab_q     <= in_tab;
			last_q    <= s_tlast;
			cur_pos_q <= pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			f_q       <= '0;
			pos_q     <= '0;
			acc_vld_q <= '0;
			m_vld_q   <= 1'b0;
		end else begin
			if (m_load)
				m_vld_q <= 1'b1;
			else if (m_tready)
				m_vld_q <= 1'b0;
			if (acc_we)
				acc_vld_q[f_s2] <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (s_xfer && req_kind_t'(s_tuser) == REQ_COORD) begin
						f_q     <= '0;
						state_q <= ST_ACC;
						if (s_tlast || 32'(pos_q) == DIM - 1)
							pos_q <= '0;
						else
							pos_q <= pos_q + 1'b1;
					end
				end
				ST_ACC: begin
					if (f_q == FC_W'(NUM_FUNCS - 1))
						state_q <= ST_DRAIN;
					else
						f_q <= f_q + 1'b1;
				end
				ST_DRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						f_q     <= '0;
						state_q <= last_q ? ST_FIN_RD : ST_IDLE;
					end
				end
				ST_FIN_RD:   state_q <= ST_FIN_CALC;
				ST_FIN_CALC: state_q <= ST_FIN_DIV;
				ST_FIN_DIV: begin
					if (div_rsp.done)
						state_q <= ST_FIN_MUL;
				end
				ST_FIN_MUL:  state_q <= ST_FIN_SUM;
				ST_FIN_SUM: begin
					if (f_q == k_use - 1'b1) begin
						state_q <= ST_BKT_ST;
					end else begin
						f_q     <= f_q + 1'b1;
						state_q <= ST_FIN_RD;
					end
				end
				ST_BKT_ST:   state_q <= ST_BKT_DIV;
				ST_BKT_DIV: begin
					if (div_rsp.done) begin
						acc_vld_q <= '0;
						f_q       <= '0;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (m_load) begin
						if (f_q == k_use - 1'b1)
							state_q <= ST_IDLE;
						else
							f_q <= f_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_vld_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

endmodule

### hw/rtl/elsh_chk.sv
module elsh_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [1:0]                     s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [elsh_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tlast
);
	import elsh_pkg::*;

	// a stalled result holds
	a_m_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// the block only goes busy on a transfer
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid && s_tready))
		else $error("ready dropped without a transfer");

	// store loads do not leave the block busy
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != REQ_COORD |=> s_tready)
		else $error("load item left the block busy");

	// every result of one point carries the same bucket
	a_same_bucket: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			!m_tvalid || m_tdata[59:36] == $past(m_tdata[59:36]))
		else $error("bucket changed within a point");

endmodule

bind euclidean_lsh_bucket_hash elsh_chk u_elsh_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
